// ----- rtl/bcg_pkg.sv -----
// Shared constants, curve tables and types of the battery charge gauge.
`default_nettype none

package bcg_pkg;

  // Field and register widths
  localparam int AVG_SAMPLES = 5;
  localparam int ADC_BITS    = 12;
  localparam int VOLT_W      = 13;
  localparam int REF_W       = 13;
  localparam int MIN_CHG_W   = 10;
  localparam int PCT_W       = 7;
  localparam int LEVEL_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  localparam int VOLT_MAX = (1 << VOLT_W) - 1;
  localparam int ADC_MAX  = (1 << ADC_BITS) - 1;

  // Averaging ring and divide-by-N through a rounded-up reciprocal
  localparam int SLOT_W      = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int SUM_W       = VOLT_W + $clog2(AVG_SAMPLES);
  localparam int AVG_DIV_SH  = SUM_W + $clog2(AVG_SAMPLES);
  localparam int AVG_RECIP   = ((1 << AVG_DIV_SH) + AVG_SAMPLES - 1) / AVG_SAMPLES;
  localparam int RECIP_W     = SUM_W + 2;

  // Raw code times reference
  localparam int X_W = ADC_BITS + REF_W;

  // Shared multiplier
  localparam int MUL_A_W = (ADC_BITS > SUM_W) ? ADC_BITS : SUM_W;
  localparam int MUL_B_W = (RECIP_W > REF_W) ? RECIP_W : REF_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Discharge curve, highest voltage first
  localparam int CURVE_N = 11;
  localparam int SPAN_W  = 8;
  localparam int DP_W    = 4;
  localparam int NUM_W   = 13;
  localparam int QUO_W   = 4;
  localparam int BIT_W   = 2;

  localparam logic [VOLT_W-1:0] CURVE_MV [CURVE_N] = '{
    13'd3200, 13'd3000, 13'd2900, 13'd2800, 13'd2700, 13'd2600,
    13'd2500, 13'd2400, 13'd2300, 13'd2200, 13'd2000
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_N] = '{
    7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd55, 7'd40, 7'd25, 7'd10, 7'd5, 7'd0
  };

  // Stream packing
  localparam int IN_DATA_W    = ((ADC_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VOLT_W + PCT_W + LEVEL_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic fill;
    logic push;
    logic sum_clr;
    logic sum_add;
  } ring_ctrl_t;

  typedef struct packed {
    logic              above;
    logic              below;
    logic [VOLT_W-1:0] lo_mv;
    logic [PCT_W-1:0]  pct_lo;
    logic [DP_W-1:0]   dp;
    logic [SPAN_W-1:0] span;
  } seg_t;

endpackage

`default_nettype wire

// ----- rtl/bcg_mul.sv -----
// Shared multiplier with a registered product.
`default_nettype none

module bcg_mul (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [bcg_pkg::MUL_A_W-1:0]  a_i,
  input  wire logic [bcg_pkg::MUL_B_W-1:0]  b_i,
  output logic      [bcg_pkg::PROD_W-1:0]   prod_o
);
  import bcg_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- rtl/bcg_ring.sv -----
// Sample ring for the moving average, with a one-entry-per-cycle accumulator.
`default_nettype none

module bcg_ring (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bcg_pkg::ring_ctrl_t         ctrl_i,
  input  wire logic [bcg_pkg::VOLT_W-1:0]  v_i,
  output logic      [bcg_pkg::SUM_W-1:0]   sum_o,
  output logic                             last_o
);
  import bcg_pkg::*;

  logic [VOLT_W-1:0] ring_q [AVG_SAMPLES];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] rd_idx_q, rd_idx_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              slot_end, rd_end;

  assign slot_end = (slot_q == SLOT_W'(AVG_SAMPLES - 1));
  assign rd_end   = (rd_idx_q == SLOT_W'(AVG_SAMPLES - 1));

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < AVG_SAMPLES; i++) begin
      if (ctrl_i.fill || (ctrl_i.push && slot_q == SLOT_W'(i))) begin
        ring_q[i] <= v_i;
      end
    end
  end

  always_comb begin
    slot_d   = slot_q;
    rd_idx_d = rd_idx_q;
    sum_d    = sum_q;
    if (ctrl_i.push) begin
      slot_d = slot_end ? '0 : slot_q + SLOT_W'(1);
    end
    if (ctrl_i.sum_clr) begin
      rd_idx_d = '0;
      sum_d    = '0;
    end else if (ctrl_i.sum_add) begin
      rd_idx_d = rd_end ? '0 : rd_idx_q + SLOT_W'(1);
      sum_d    = sum_q + SUM_W'(ring_q[rd_idx_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      rd_idx_q <= '0;
      sum_q    <= '0;
    end else begin
      slot_q   <= slot_d;
      rd_idx_q <= rd_idx_d;
      sum_q    <= sum_d;
    end
  end

  assign sum_o  = sum_q;
  assign last_o = rd_end;

endmodule

`default_nettype wire

// ----- rtl/bcg_map.sv -----
// Discharge curve segment decode: end clamps and interpolation terms.
`default_nettype none

module bcg_map (
  input  wire logic [bcg_pkg::VOLT_W-1:0] avg_i,
  output bcg_pkg::seg_t                   seg_o
);
  import bcg_pkg::*;

  always_comb begin
    seg_o.above  = (avg_i >= CURVE_MV[0]);
    seg_o.below  = (avg_i <= CURVE_MV[CURVE_N-1]);
    seg_o.lo_mv  = CURVE_MV[CURVE_N-1];
    seg_o.pct_lo = CURVE_PCT[CURVE_N-1];
    seg_o.dp     = '0;
    seg_o.span   = '0;
    // highest-voltage matching segment wins, as the downward scan ends on it
    for (int i = CURVE_N - 2; i >= 0; i--) begin
      if (avg_i <= CURVE_MV[i] && avg_i >= CURVE_MV[i+1]) begin
        seg_o.lo_mv  = CURVE_MV[i+1];
        seg_o.pct_lo = CURVE_PCT[i+1];
        seg_o.dp     = DP_W'(CURVE_PCT[i] - CURVE_PCT[i+1]);
        seg_o.span   = SPAN_W'(CURVE_MV[i] - CURVE_MV[i+1]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/battery_charge_gauge.sv -----
// Voltage-based battery charge gauge: sequencer, config registers and stream ports.
//
// One battery sample enters per transaction on the s_axis channel (tdata bits 11:0).
// One result leaves per sample on the m_axis channel: tuser is the refresh flag,
// tdata holds the reported voltage, percentage and level. Registers are written
// via the cfg channel (always ready); the user must do so only while idle (not enforced).
//
// An item runs through one shared multiplier under the sequencer: raw scaling
// (multiply, then fold steps for the divide by the ADC full scale), ring write,
// accumulation over the ring entries, multiply by the reciprocal of the ring depth,
// change test, interpolation multiply and a 4-step restoring divide, limiter.
// A millivolt sample skips the raw scaling; a curve end skips the interpolation
// multiply and divide; a sample with no refresh goes from the change test to the
// output; the first sample after reset skips the accumulation and the average.
// s_axis_tready is high only in the idle state, once the previous sample is done.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the sequencer holds its next result until m_axis_tready.
// Reset clears the ring state, reported values and registers to their defaults;
// the first sample after reset fills the whole ring.
`default_nettype none

module battery_charge_gauge (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input: [11:0] sample
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [bcg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // output: [12:0] volt_mv, [19:13] percent, [22:20] level
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [bcg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // output: [0] updated
  output logic                                    m_axis_tuser,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bcg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bcg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bcg_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_MV    = 3'd0,
    REG_REF_MV   = 3'd1,
    REG_MIN_CHG  = 3'd2,
    REG_MAX_STEP = 3'd3,
    REG_DEADBAND = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LOAD,
    ST_FOLD,
    ST_STORE,
    ST_SUM,
    ST_AVG,
    ST_AVGQ,
    ST_CHECK,
    ST_NUM,
    ST_DIV,
    ST_LIMIT,
    ST_DONE
  } state_e;

  localparam logic [PCT_W-1:0] LVL1_PCT = 7'd5;
  localparam logic [PCT_W-1:0] LVL2_PCT = 7'd25;
  localparam logic [PCT_W-1:0] LVL3_PCT = 7'd50;
  localparam logic [PCT_W-1:0] LVL4_PCT = 7'd75;

  function automatic logic [VOLT_W-1:0] sat_volt(input logic [X_W-1:0] x);
    return (x > X_W'(VOLT_MAX)) ? VOLT_W'(VOLT_MAX) : x[VOLT_W-1:0];
  endfunction

  function automatic logic [PCT_W-1:0] limit_pct(input logic [PCT_W-1:0] fresh,
                                                 input logic [PCT_W-1:0] cur,
                                                 input logic [PCT_W-1:0] band,
                                                 input logic [PCT_W-1:0] step);
    logic [PCT_W-1:0] diff;
    logic [PCT_W:0]   up;
    logic [PCT_W-1:0] res;
    diff = (fresh > cur) ? fresh - cur : cur - fresh;
    up   = {1'b0, cur} + {1'b0, step};
    if (cur == '0) begin
      res = fresh;
    end else if (diff <= band) begin
      res = cur;
    end else if (fresh > cur && diff > step) begin
      res = up[PCT_W-1:0];
    end else if (fresh < cur && diff > step) begin
      res = cur - step;
    end else begin
      res = fresh;
    end
    return res;
  endfunction

  function automatic logic [LEVEL_W-1:0] level_of(input logic [PCT_W-1:0] p);
    logic [LEVEL_W-1:0] l;
    if (p < LVL1_PCT) begin
      l = 3'd0;
    end else if (p < LVL2_PCT) begin
      l = 3'd1;
    end else if (p < LVL3_PCT) begin
      l = 3'd2;
    end else if (p < LVL4_PCT) begin
      l = 3'd3;
    end else begin
      l = 3'd4;
    end
    return l;
  endfunction

  state_e                state_q, state_d;
  logic [ADC_BITS-1:0]   sample_q, sample_d;
  logic [X_W-1:0]        t_q, t_d;
  logic [X_W-1:0]        quot_q, quot_d;
  logic [VOLT_W-1:0]     v_q, v_d;
  logic [VOLT_W-1:0]     avg_q, avg_d;
  logic                  primed_q, primed_d;
  logic [VOLT_W-1:0]     rep_v_q, rep_v_d;
  logic [PCT_W-1:0]      rep_p_q, rep_p_d;
  logic [LEVEL_W-1:0]    rep_l_q, rep_l_d;
  logic                  upd_q, upd_d;
  logic [PCT_W-1:0]      fresh_q, fresh_d;
  logic [NUM_W-1:0]      num_q, num_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic [BIT_W-1:0]      bit_q, bit_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_user_q, out_user_d;
  logic                  in_mv_q, in_mv_d;
  logic [REF_W-1:0]      ref_mv_q, ref_mv_d;
  logic [MIN_CHG_W-1:0]  min_chg_q, min_chg_d;
  logic [PCT_W-1:0]      max_step_q, max_step_d;
  logic [PCT_W-1:0]      deadband_q, deadband_d;

  logic                  mul_en;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod;
  ring_ctrl_t            ring_ctrl;
  logic [SUM_W-1:0]      ring_sum;
  logic                  ring_last;
  seg_t                  seg;

  logic [REF_W-1:0]      fold_hi;
  logic [ADC_BITS-1:0]   fold_lo;
  logic [VOLT_W-1:0]     avg_diff;
  logic [VOLT_W-1:0]     seg_off;
  logic [NUM_W-1:0]      div_sh;
  logic                  div_ge;
  logic [QUO_W-1:0]      quo_n;
  logic [PCT_W-1:0]      lim_p;
  logic                  in_hs;
  logic                  cfg_hs;

  bcg_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bcg_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .v_i    (v_q),
    .sum_o  (ring_sum),
    .last_o (ring_last)
  );

  bcg_map u_map (
    .avg_i (avg_q),
    .seg_o (seg)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_hs        = cfg_valid_i;

  // x = q*ADC_MAX + t; fold t's high part back in until it fits ADC_BITS
  assign fold_hi  = t_q[X_W-1:ADC_BITS];
  assign fold_lo  = t_q[ADC_BITS-1:0];
  assign avg_diff = (avg_q > rep_v_q) ? avg_q - rep_v_q : rep_v_q - avg_q;
  assign seg_off  = avg_q - seg.lo_mv;
  assign div_sh   = NUM_W'({seg.span, 1'b0}) << bit_q;
  assign div_ge   = (num_q >= div_sh);
  assign quo_n    = quo_q | (QUO_W'(div_ge) << bit_q);
  assign lim_p    = limit_pct(fresh_q, rep_p_q, deadband_q, max_step_q);

  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    t_d         = t_q;
    quot_d      = quot_q;
    v_d         = v_q;
    avg_d       = avg_q;
    primed_d    = primed_q;
    rep_v_d     = rep_v_q;
    rep_p_d     = rep_p_q;
    rep_l_d     = rep_l_q;
    upd_d       = upd_q;
    fresh_d     = fresh_q;
    num_d       = num_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    in_mv_d     = in_mv_q;
    ref_mv_d    = ref_mv_q;
    min_chg_d   = min_chg_q;
    max_step_d  = max_step_q;
    deadband_d  = deadband_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    ring_ctrl   = '0;

    if (cfg_hs) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IN_MV:    in_mv_d    = cfg_data_i[0];
        REG_REF_MV:   ref_mv_d   = cfg_data_i[REF_W-1:0];
        REG_MIN_CHG:  min_chg_d  = cfg_data_i[MIN_CHG_W-1:0];
        REG_MAX_STEP: max_step_d = cfg_data_i[PCT_W-1:0];
        REG_DEADBAND: deadband_d = cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          sample_d = s_axis_tdata[ADC_BITS-1:0];
          if (in_mv_q) begin
            v_d     = sat_volt(X_W'(s_axis_tdata[ADC_BITS-1:0]));
            state_d = ST_STORE;
          end else begin
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(sample_q);
        mul_b   = MUL_B_W'(ref_mv_q);
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        t_d     = prod[X_W-1:0];
        quot_d  = '0;
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        if (fold_hi != '0) begin
          quot_d = quot_q + X_W'(fold_hi);
          t_d    = X_W'(fold_hi) + X_W'(fold_lo);
        end else begin
          v_d     = sat_volt(quot_q + X_W'(fold_lo == ADC_BITS'(ADC_MAX)));
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        if (!primed_q) begin
          ring_ctrl.fill = 1'b1;
          primed_d       = 1'b1;
          avg_d          = v_q;
          state_d        = ST_CHECK;
        end else begin
          ring_ctrl.push    = 1'b1;
          ring_ctrl.sum_clr = 1'b1;
          state_d           = ST_SUM;
        end
      end
      ST_SUM: begin
        ring_ctrl.sum_add = 1'b1;
        if (ring_last) begin
          state_d = ST_AVG;
        end
      end
      ST_AVG: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(ring_sum);
        mul_b   = MUL_B_W'(AVG_RECIP);
        state_d = ST_AVGQ;
      end
      ST_AVGQ: begin
        avg_d   = prod[AVG_DIV_SH +: VOLT_W];
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (avg_diff >= VOLT_W'(min_chg_q)) begin
          if (seg.above) begin
            fresh_d = CURVE_PCT[0];
            state_d = ST_LIMIT;
          end else if (seg.below) begin
            fresh_d = CURVE_PCT[CURVE_N-1];
            state_d = ST_LIMIT;
          end else begin
            mul_en  = 1'b1;
            mul_a   = MUL_A_W'(seg_off[SPAN_W-1:0]);
            mul_b   = MUL_B_W'(seg.dp);
            state_d = ST_NUM;
          end
        end else begin
          upd_d   = 1'b0;
          state_d = ST_DONE;
        end
      end
      ST_NUM: begin
        // round half up: (2*off*dp + span) / (2*span)
        num_d   = NUM_W'({prod[NUM_W-2:0], 1'b0}) + NUM_W'(seg.span);
        quo_d   = '0;
        bit_d   = BIT_W'(QUO_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_ge) begin
          num_d = num_q - div_sh;
        end
        quo_d = quo_n;
        if (bit_q == '0) begin
          fresh_d = seg.pct_lo + PCT_W'(quo_n);
          state_d = ST_LIMIT;
        end else begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      ST_LIMIT: begin
        rep_v_d = avg_q;
        rep_p_d = lim_p;
        rep_l_d = level_of(lim_p);
        upd_d   = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_DATA_W'({rep_l_q, rep_p_q, rep_v_q});
          out_user_d  = upd_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sample_q    <= '0;
      t_q         <= '0;
      quot_q      <= '0;
      v_q         <= '0;
      avg_q       <= '0;
      primed_q    <= 1'b0;
      rep_v_q     <= '0;
      rep_p_q     <= '0;
      rep_l_q     <= '0;
      upd_q       <= 1'b0;
      fresh_q     <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= 1'b0;
      in_mv_q     <= 1'b0;
      ref_mv_q    <= REF_W'(1100);
      min_chg_q   <= MIN_CHG_W'(20);
      max_step_q  <= PCT_W'(5);
      deadband_q  <= PCT_W'(2);
    end else begin
      state_q     <= state_d;
      sample_q    <= sample_d;
      t_q         <= t_d;
      quot_q      <= quot_d;
      v_q         <= v_d;
      avg_q       <= avg_d;
      primed_q    <= primed_d;
      rep_v_q     <= rep_v_d;
      rep_p_q     <= rep_p_d;
      rep_l_q     <= rep_l_d;
      upd_q       <= upd_d;
      fresh_q     <= fresh_d;
      num_q       <= num_d;
      quo_q       <= quo_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_user_q  <= out_user_d;
      in_mv_q     <= in_mv_d;
      ref_mv_q    <= ref_mv_d;
      min_chg_q   <= min_chg_d;
      max_step_q  <= max_step_d;
      deadband_q  <= deadband_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire
